// File: sv/fpa_pkg.sv
package fpa_pkg;

    localparam int FRAC_BITS_DEF = 8;
    localparam int WORD_BITS_DEF = 32;

    typedef enum logic [3:0] {
        FN_ADD  = 4'd0,
        FN_SUB  = 4'd1,
        FN_MUL  = 4'd2,
        FN_DIV  = 4'd3,
        FN_LT   = 4'd4,
        FN_GT   = 4'd5,
        FN_LE   = 4'd6,
        FN_GE   = 4'd7,
        FN_EQ   = 4'd8,
        FN_NE   = 4'd9,
        FN_MIN  = 4'd10,
        FN_MAX  = 4'd11,
        FN_INC  = 4'd12,
        FN_DEC  = 4'd13,
        FN_FROM = 4'd14,
        FN_TO   = 4'd15
    } t_func;

endpackage

// File: sv/fpa_div.sv
module fpa_div #(
    parameter int WORD_BITS = fpa_pkg::WORD_BITS_DEF,
    parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF,
    parameter int TAG_BITS  = 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic [WORD_BITS-1:0] i_num,
    input  logic [WORD_BITS-1:0] i_den,
    input  logic [TAG_BITS-1:0]  i_tag,
    output logic                 o_valid,
    output logic [WORD_BITS+FRAC_BITS-1:0] o_quo,
    output logic [WORD_BITS-1:0] o_rem,
    output logic [WORD_BITS-1:0] o_den,
    output logic [TAG_BITS-1:0]  o_tag
);

    localparam int NB = WORD_BITS + FRAC_BITS;

    for (genvar s = 0; s < NB; s++) begin : g_st
        logic                 s_v;
        logic [NB-1:0]        s_n;
        logic [WORD_BITS:0]   s_r;
        logic [WORD_BITS-1:0] s_d;
        logic [TAG_BITS-1:0]  s_t;
        logic                 r_v;
        logic [NB-1:0]        r_n;
        logic [WORD_BITS:0]   r_r;
        logic [WORD_BITS-1:0] r_d;
        logic [TAG_BITS-1:0]  r_t;
        logic [WORD_BITS+1:0] n_sh;
        logic [WORD_BITS+1:0] n_df;
        if (s == 0) begin : g_in
            assign s_v = i_valid;
            assign s_n = {i_num, {FRAC_BITS{1'b0}}};
            assign s_r = '0;
            assign s_d = i_den;
            assign s_t = i_tag;
        end else begin : g_mid
            assign s_v = g_st[s-1].r_v;
            assign s_n = g_st[s-1].r_n;
            assign s_r = g_st[s-1].r_r;
            assign s_d = g_st[s-1].r_d;
            assign s_t = g_st[s-1].r_t;
        end
        always_comb begin
            n_sh = {s_r, s_n[NB-1]};
            n_df = n_sh - {2'b00, s_d};
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else if (i_en) begin
                r_v <= s_v;
            end
            if (i_en) begin
                r_d <= s_d;
                r_t <= s_t;
                if (!n_df[WORD_BITS+1]) begin
                    r_r <= n_df[WORD_BITS:0];
                    r_n <= {s_n[NB-2:0], 1'b1};
                end else begin
                    r_r <= n_sh[WORD_BITS:0];
                    r_n <= {s_n[NB-2:0], 1'b0};
                end
            end
        end
    end

    assign o_valid = g_st[NB-1].r_v;
    assign o_quo   = g_st[NB-1].r_n;
    assign o_rem   = g_st[NB-1].r_r[WORD_BITS-1:0];
    assign o_den   = g_st[NB-1].r_d;
    assign o_tag   = g_st[NB-1].r_t;

endmodule

// File: sv/fixed_point_q24_8_alu.sv
// Signed fixed-point ALU (Q24.8 by default). One beat enters per cycle unless the output stalls;
// every beat passes stage 1, stage 2, the restoring divider pipeline (one quotient bit per stage)
// and the final output register; all operations share that path so results leave in order.
// A stall on the output freezes the whole pipeline.
module fixed_point_q24_8_alu #(
    parameter int WORD_BITS = fpa_pkg::WORD_BITS_DEF,
    parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [3:0]                  i_func,
    input  logic signed [WORD_BITS-1:0] i_operand_a,
    input  logic signed [WORD_BITS-1:0] i_operand_b,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic signed [WORD_BITS-1:0] o_value_out,
    output logic                        o_compare_true,
    output logic                        o_overflowed,
    output logic                        o_divided_by_zero
);

    localparam int W  = WORD_BITS;
    localparam int PW = 2 * W;
    localparam int TB = 4 + 1 + PW + W + 2;
    localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

    logic en;
    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;

    // stage 1: magnitudes, simple ops
    logic [W-1:0] n_ma, n_mb;
    logic [W-1:0] n_sv;
    logic         n_scmp, n_sov;
    logic [W:0]   n_sum;
    logic signed [W:0] n_ext;
    logic signed [W+FRAC_BITS:0] n_fi;
    always_comb begin
        n_ma  = i_operand_a[W-1] ? (W)'(-i_operand_a) : i_operand_a;
        n_mb  = i_operand_b[W-1] ? (W)'(-i_operand_b) : i_operand_b;
        n_sv  = '0;
        n_scmp = 1'b0;
        n_sov = 1'b0;
        n_sum = '0;
        n_ext = '0;
        n_fi  = '0;
        case (fpa_pkg::t_func'(i_func))
            fpa_pkg::FN_ADD, fpa_pkg::FN_SUB, fpa_pkg::FN_INC, fpa_pkg::FN_DEC: begin
                if (i_func == fpa_pkg::FN_ADD)
                    n_ext = {i_operand_a[W-1], i_operand_a} + {i_operand_b[W-1], i_operand_b};
                else if (i_func == fpa_pkg::FN_SUB)
                    n_ext = {i_operand_a[W-1], i_operand_a} - {i_operand_b[W-1], i_operand_b};
                else if (i_func == fpa_pkg::FN_INC)
                    n_ext = {i_operand_a[W-1], i_operand_a} + (W+1)'(1);
                else
                    n_ext = {i_operand_a[W-1], i_operand_a} - (W+1)'(1);
                n_sum = n_ext;
                if (n_sum[W] != n_sum[W-1]) begin
                    n_sov = 1'b1;
                    n_sv  = n_sum[W] ? MINV : MAXV;
                end else begin
                    n_sv = n_sum[W-1:0];
                end
            end
            fpa_pkg::FN_LT:  n_scmp = i_operand_a < i_operand_b;
            fpa_pkg::FN_GT:  n_scmp = i_operand_b < i_operand_a;
            fpa_pkg::FN_LE:  n_scmp = !(i_operand_b < i_operand_a);
            fpa_pkg::FN_GE:  n_scmp = !(i_operand_a < i_operand_b);
            fpa_pkg::FN_EQ:  n_scmp = i_operand_a == i_operand_b;
            fpa_pkg::FN_NE:  n_scmp = i_operand_a != i_operand_b;
            fpa_pkg::FN_MIN: n_sv = (i_operand_a < i_operand_b) ? i_operand_a : i_operand_b;
            fpa_pkg::FN_MAX: n_sv = (i_operand_b < i_operand_a) ? i_operand_a : i_operand_b;
            fpa_pkg::FN_FROM: begin
                n_fi = {i_operand_a[W-1], i_operand_a, {FRAC_BITS{1'b0}}};
                if (n_fi > (W+FRAC_BITS+1)'($signed(MAXV))) begin
                    n_sov = 1'b1;
                    n_sv  = MAXV;
                end else if (n_fi < (W+FRAC_BITS+1)'($signed(MINV))) begin
                    n_sov = 1'b1;
                    n_sv  = MINV;
                end else begin
                    n_sv = n_fi[W-1:0];
                end
            end
            fpa_pkg::FN_TO:  n_sv = W'(i_operand_a >>> FRAC_BITS);
            default: n_sv = '0;
        endcase
    end

    logic         r1_v;
    logic [3:0]   r1_f;
    logic         r1_neg;
    logic [W-1:0] r1_ma, r1_mb, r1_sv;
    logic         r1_scmp, r1_sov;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (en) begin
            r1_v <= i_valid;
        end
        if (en) begin
            r1_f    <= i_func;
            r1_neg  <= i_operand_a[W-1] ^ i_operand_b[W-1];
            r1_ma   <= n_ma;
            r1_mb   <= n_mb;
            r1_sv   <= n_sv;
            r1_scmp <= n_scmp;
            r1_sov  <= n_sov;
        end
    end

    // stage 2: product, registered
    logic         r2_v;
    logic [3:0]   r2_f;
    logic         r2_neg;
    logic [PW-1:0] r2_p;
    logic [W-1:0] r2_ma, r2_mb;
    logic [W-1:0] r2_sv;
    logic         r2_scmp, r2_sov;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (en) begin
            r2_v <= r1_v;
        end
        if (en) begin
            r2_f    <= r1_f;
            r2_neg  <= r1_neg;
            r2_p    <= PW'(r1_ma) * PW'(r1_mb);
            r2_ma   <= r1_ma;
            r2_mb   <= r1_mb;
            r2_sv   <= r1_sv;
            r2_scmp <= r1_scmp;
            r2_sov  <= r1_sov;
        end
    end

    // divider runs in parallel; other results ride on its tag
    logic [TB-1:0] d_tag_in, d_tag_out;
    logic          d_v;
    logic [W+FRAC_BITS-1:0] d_quo;
    logic [W-1:0]  d_rem, d_den;
    assign d_tag_in = {r2_f, r2_neg, r2_p, r2_sv, r2_scmp, r2_sov};

    fpa_div #(.WORD_BITS(W), .FRAC_BITS(FRAC_BITS), .TAG_BITS(TB)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r2_v),
        .i_num   (r2_ma),
        .i_den   (r2_mb),
        .i_tag   (d_tag_in),
        .o_valid (d_v),
        .o_quo   (d_quo),
        .o_rem   (d_rem),
        .o_den   (d_den),
        .o_tag   (d_tag_out)
    );

    // final stage
    logic [3:0]    f_f;
    logic          f_neg;
    logic [PW-1:0] f_p;
    logic [W-1:0]  f_sv;
    logic          f_scmp, f_sov;
    assign {f_f, f_neg, f_p, f_sv, f_scmp, f_sov} = d_tag_out;

    logic [PW:0]   n_pr;
    logic [PW:0]   n_mm;
    logic [W:0]    n_q;
    logic [W+FRAC_BITS:0] n_qr;
    logic [W-1:0]  n_v;
    logic          n_ov, n_dz, n_c;
    always_comb begin
        n_v  = f_sv;
        n_ov = f_sov;
        n_dz = 1'b0;
        n_c  = f_scmp;
        n_pr = '0;
        n_mm = '0;
        n_q  = '0;
        n_qr = '0;
        if (f_f == fpa_pkg::FN_MUL) begin
            n_pr = {1'b0, f_p} + (PW+1)'(1 << (FRAC_BITS - 1));
            n_mm = n_pr >> FRAC_BITS;
            if (n_mm > (PW+1)'({1'b0, MAXV}) + (PW+1)'(f_neg)) begin
                n_ov = 1'b1;
                n_v  = f_neg ? MINV : MAXV;
            end else begin
                n_v = f_neg ? W'(-n_mm[W-1:0]) : n_mm[W-1:0];
            end
        end else if (f_f == fpa_pkg::FN_DIV) begin
            if (d_den == '0) begin
                n_dz = 1'b1;
                n_v  = '0;
            end else begin
                n_q  = {1'b0, d_den} - {1'b0, d_rem};
                n_qr = {1'b0, d_quo} + (W+FRAC_BITS+1)'({1'b0, d_rem} >= n_q);
                if (n_qr > (W+FRAC_BITS+1)'({1'b0, MAXV}) + (W+FRAC_BITS+1)'(f_neg)) begin
                    n_ov = 1'b1;
                    n_v  = f_neg ? MINV : MAXV;
                end else begin
                    n_v = f_neg ? W'(-n_qr[W-1:0]) : n_qr[W-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (en) begin
            o_valid <= d_v;
        end
        if (en) begin
            o_value_out       <= n_v;
            o_compare_true    <= n_c;
            o_overflowed      <= n_ov;
            o_divided_by_zero <= n_dz;
        end
    end

`ifndef SYNTH
    a_dz_only_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_divided_by_zero && (o_overflowed || o_compare_true)))
        else $error("divide by zero with other flags");
    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_divided_by_zero) |-> (o_value_out == '0))
        else $error("divide by zero value not zero");
    a_cmp_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_compare_true) |-> (o_value_out == '0 && !o_overflowed))
        else $error("compare with value");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_value_out)))
        else $error("stalled beat changed");
`endif

endmodule

// File: bench/alu_checker.sv
module alu_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic [3:0]         i_func,
    input  logic signed [31:0] i_a,
    input  logic signed [31:0] i_b,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic signed [31:0] i_value,
    input  logic               i_cmp,
    input  logic               i_ovf,
    input  logic               i_dz,
    output int                 o_errors,
    output int                 o_pending,
    output int                 o_results
);

    typedef struct packed {
        logic signed [31:0] value;
        logic               cmp;
        logic               ovf;
        logic               dz;
    } t_alu_result;

    t_alu_result expected_q[$];

    localparam logic signed [63:0] WMAX = 64'sd2147483647;
    localparam logic signed [63:0] WMIN = -64'sd2147483648;

    function automatic t_alu_result saturate(input logic signed [127:0] v);
        t_alu_result r;
        r = '0;
        if (v > WMAX) begin
            r.value = WMAX[31:0];
            r.ovf = 1'b1;
        end else if (v < WMIN) begin
            r.value = WMIN[31:0];
            r.ovf = 1'b1;
        end else begin
            r.value = v[31:0];
        end
        return r;
    endfunction

    // exact rounding, half away from zero, for multiply and divide
    function automatic t_alu_result alu_predict(input fpa_pkg::t_func fn,
                                                input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        t_alu_result r;
        logic signed [127:0] wa, wb, num, q;
        logic [127:0] ma, mb, mq, rem;
        logic neg;
        r = '0;
        wa = a;
        wb = b;
        neg = a[31] ^ b[31];
        case (fn)
            fpa_pkg::FN_ADD: r = saturate(wa + wb);
            fpa_pkg::FN_SUB: r = saturate(wa - wb);
            fpa_pkg::FN_MUL: begin
                ma = wa < 0 ? -wa : wa;
                mb = wb < 0 ? -wb : wb;
                mq = (ma * mb + 128) >> 8;
                q = neg ? -$signed(mq) : $signed(mq);
                r = saturate(q);
            end
            fpa_pkg::FN_DIV: begin
                if (b == 0) begin
                    r.dz = 1'b1;
                end else begin
                    ma = wa < 0 ? -wa : wa;
                    mb = wb < 0 ? -wb : wb;
                    num = ma << 8;
                    mq = num / mb;
                    rem = num % mb;
                    if (rem >= mb - rem) mq = mq + 1;
                    q = neg ? -$signed(mq) : $signed(mq);
                    r = saturate(q);
                end
            end
            fpa_pkg::FN_LT: r.cmp = a < b;
            fpa_pkg::FN_GT: r.cmp = a > b;
            fpa_pkg::FN_LE: r.cmp = a <= b;
            fpa_pkg::FN_GE: r.cmp = a >= b;
            fpa_pkg::FN_EQ: r.cmp = a == b;
            fpa_pkg::FN_NE: r.cmp = a != b;
            fpa_pkg::FN_MIN: r.value = a < b ? a : b;
            fpa_pkg::FN_MAX: r.value = b < a ? a : b;
            fpa_pkg::FN_INC: r = saturate(wa + 1);
            fpa_pkg::FN_DEC: r = saturate(wa - 1);
            fpa_pkg::FN_FROM: r = saturate(wa * 256);
            default: r.value = a >>> 8;
        endcase
        return r;
    endfunction

    always_ff @(posedge i_clk) begin
        t_alu_result got, exp_r;
        if (!i_rst_n) begin
            o_errors <= 0;
            o_results <= 0;
            expected_q.delete();
        end else begin
            if (i_in_valid && !i_in_stall)
                expected_q.push_back(alu_predict(fpa_pkg::t_func'(i_func), i_a, i_b));
            if (i_out_valid && !i_out_stall) begin
                o_results <= o_results + 1;
                got = {i_value, i_cmp, i_ovf, i_dz};
                if (expected_q.size() == 0) begin
                    $error("result beat with nothing expected");
                    o_errors <= o_errors + 1;
                end else begin
                    exp_r = expected_q.pop_front();
                    if (got != exp_r) begin
                        o_errors <= o_errors + 1;
                        if (got.value != exp_r.value)
                            $error("value_out exp %0d got %0d", exp_r.value, got.value);
                        if (got.cmp != exp_r.cmp)
                            $error("compare_true exp %0d got %0d", exp_r.cmp, got.cmp);
                        if (got.ovf != exp_r.ovf)
                            $error("overflowed exp %0d got %0d", exp_r.ovf, got.ovf);
                        if (got.dz != exp_r.dz)
                            $error("divided_by_zero exp %0d got %0d", exp_r.dz, got.dz);
                    end
                end
            end
        end
    end

    assign o_pending = expected_q.size();
endmodule

// File: bench/tb_top.sv
module tb_top;

    localparam int LIMIT = 400000;

    logic               clk;
    logic               rst_n;
    logic               in_valid, in_stall, out_valid, out_stall;
    logic [3:0]         func;
    logic signed [31:0] opa, opb, value;
    logic               cmp, ovf, dz;
    int                 errors, pending, results;
    int                 cycles;
    int                 sent;

    fixed_point_q24_8_alu u_top (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(in_valid), .o_stall(in_stall),
        .i_func(func), .i_operand_a(opa), .i_operand_b(opb),
        .o_valid(out_valid), .i_stall(out_stall), .o_value_out(value),
        .o_compare_true(cmp), .o_overflowed(ovf), .o_divided_by_zero(dz)
    );

    alu_checker u_checker (
        .i_clk(clk), .i_rst_n(rst_n), .i_in_valid(in_valid), .i_in_stall(in_stall),
        .i_func(func), .i_a(opa), .i_b(opb), .i_out_valid(out_valid),
        .i_out_stall(out_stall), .i_value(value), .i_cmp(cmp), .i_ovf(ovf), .i_dz(dz),
        .o_errors(errors), .o_pending(pending), .o_results(results)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 45) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    function automatic logic signed [31:0] pick_word();
        case ($urandom_range(0, 9))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return $signed(32'($urandom_range(0, 1024))) - 512;
            3: return 0;
            4, 5: return $signed(32'($urandom_range(0, 32'h00ffffff))) - 32'sh007fffff;
            default: return $signed($urandom());
        endcase
    endfunction

    initial begin
        cycles = 0;
        forever begin
            @(posedge clk);
            cycles++;
            if (cycles > LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // receiver back-pressure
    initial begin
        int g;
        out_stall = 1'b0;
        forever begin
            @(posedge clk);
            if (cycles > 20000 && cycles < 22000) begin
                out_stall <= 1'b0;
            end else begin
                g = gap_len();
                if (g > 0) begin
                    out_stall <= 1'b1;
                    repeat (g) @(posedge clk);
                end
                out_stall <= 1'b0;
            end
        end
    end

    task automatic send(input fpa_pkg::t_func fn, input logic signed [31:0] a,
                        input logic signed [31:0] b);
        func <= fn;
        opa <= a;
        opb <= b;
        in_valid <= 1'b1;
        do @(posedge clk); while (in_stall);
        sent++;
    endtask

    task automatic send_gap(input fpa_pkg::t_func fn, input logic signed [31:0] a,
                            input logic signed [31:0] b);
        int g;
        send(fn, a, b);
        g = gap_len();
        if (g > 0) begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    initial begin
        logic signed [31:0] a, b;
        in_valid = 1'b0;
        func = '0;
        opa = '0;
        opb = '0;
        sent = 0;
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int f = 0; f < 16; f++)
            send(fpa_pkg::t_func'(f), 32'sh7fffffff, 32'sh80000000);
        send(fpa_pkg::FN_DIV, 32'sh00000300, 0);
        send(fpa_pkg::FN_DIV, 32'sh80000000, 32'shffffffff);
        send(fpa_pkg::FN_DIV, 32'sh00000100, 32'sh00000300);
        send(fpa_pkg::FN_MUL, 32'sh00000180, 32'shffffff80);
        send(fpa_pkg::FN_MUL, 32'sh80000000, 32'sh80000000);
        send(fpa_pkg::FN_MIN, 32'sh00000500, 32'sh00000500);
        send(fpa_pkg::FN_MAX, 32'sh80000000, 32'sh80000000);
        send(fpa_pkg::FN_DEC, 32'sh80000000, 0);
        send(fpa_pkg::FN_FROM, 32'shff800000, 0);
        send(fpa_pkg::FN_TO, 32'shffffff01, 0);
        in_valid <= 1'b0;

        // drain before random traffic
        @(posedge clk);
        while (pending != 0) @(posedge clk);

        repeat (830) begin
            a = pick_word();
            b = ($urandom_range(0, 7) == 0) ? a : pick_word();
            if ($urandom_range(0, 19) == 0) b = 0;
            send_gap(fpa_pkg::t_func'($urandom_range(0, 15)), a, b);
        end
        in_valid <= 1'b0;

        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (60) @(posedge clk);
        $display("covered %0d beats in, %0d results out, all sixteen functions", sent, results);
        $display("with saturation, divide by zero and random stalls on both sides");
        if (errors == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule

// File: files.f
sv/fpa_pkg.sv
sv/fpa_div.sv
sv/fixed_point_q24_8_alu.sv
bench/alu_checker.sv
bench/tb_top.sv
